/* hdl/blr_pkg.sv */
// Shared constants and types of the bitmap line rasterizer.
package blr_pkg;

  // Bitmap geometry
  localparam int BITMAP_WIDTH  = 320;
  localparam int BITMAP_HEIGHT = 200;
  localparam int LINE_BYTES    = (BITMAP_WIDTH + 7) / 8;
  localparam int STORE_BYTES   = LINE_BYTES * BITMAP_HEIGHT;
  localparam int ADDR_W        = $clog2(STORE_BYTES);

  // Request layout
  localparam int COORD_W     = 10;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 8;

  // Request kinds carried on tuser
  localparam logic MODE_DRAW = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;

  // Sequencer commands to the line stepper
  typedef struct packed {
    logic load;
    logic advance;
  } step_ctl_t;

  // Current stepper position
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   at_end;
  } step_stat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PLOT,
    ST_MODIFY,
    ST_FETCH,
    ST_DONE
  } state_e;

endpackage

/* hdl/bitmap_line_rasterizer.sv */
// Top level: 1-bit-per-pixel bitmap with a Bresenham line drawer and pixel read.
//
//  Channel   Direction  Contents
//  s_axis    in         tuser: mode; tdata: start_x, start_y, end_x, end_y, set_on
//  m_axis    out        tdata: pixel_value
//
// A draw reads and then writes the byte of each on-bitmap pixel (on the single memory
// port pair) and steps over each off-bitmap pixel with no memory access; taking the
// request and loading the result are states of their own. At most 320 pixels of a
// line land on the bitmap, and the longest line has 1024 pixels.
// A pixel read fetches the point's byte; a point off the bitmap skips it and reads 0.
// After reset a clearing pass writes zero to all 8000 bytes, one per cycle,
// before the first request is taken.
// A stalled result holds in the output register; the next request may be taken
// meanwhile, and its result waits until the register is free.
module bitmap_line_rasterizer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [9:0] start_x, [19:10] start_y, [29:20] end_x, [39:30] end_y, [40] set_on
  input  logic [blr_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // [0] mode
  input  logic                            s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [0] pixel_value
  output logic [blr_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o
);

  blr_pkg::state_e     state_q, state_d;
  blr_pkg::step_ctl_t  step_ctl;
  blr_pkg::step_stat_t step_stat;

  logic [blr_pkg::ADDR_W-1:0] clr_q, addr_q, byte_idx, waddr;
  logic [2:0]                 bit_q;
  logic                       mode_q, set_q, pix_q, m_valid_q;
  logic                       accept, in_bmp, mem_re, mem_we, out_load;
  logic [7:0]                 rdata_q, wdata, mask;
  logic [7:0]                 mem [blr_pkg::STORE_BYTES];

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  blr_stepper u_stepper (
    .clk_i     (clk_i),
    .ctl_i     (step_ctl),
    .start_x_i (s_axis_tdata_i[9:0]),
    .start_y_i (s_axis_tdata_i[19:10]),
    .end_x_i   (s_axis_tdata_i[29:20]),
    .end_y_i   (s_axis_tdata_i[39:30]),
    .stat_o    (step_stat)
  );

  // Locate the current pixel in the store
  always_comb begin
    in_bmp = !step_stat.x[9] && !step_stat.y[9]
          && ({2'b00, step_stat.x[8:0]} < 11'(blr_pkg::BITMAP_WIDTH))
          && ({2'b00, step_stat.y[8:0]} < 11'(blr_pkg::BITMAP_HEIGHT));
    byte_idx = blr_pkg::ADDR_W'(32'(step_stat.y[8:0]) * blr_pkg::LINE_BYTES
                                + 32'(step_stat.x[8:3]));
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      blr_pkg::ST_CLEAR: begin
        if (clr_q == blr_pkg::ADDR_W'(blr_pkg::STORE_BYTES - 1)) state_d = blr_pkg::ST_IDLE;
      end
      blr_pkg::ST_IDLE: begin
        if (accept) state_d = blr_pkg::ST_PLOT;
      end
      blr_pkg::ST_PLOT: begin
        if (mode_q == blr_pkg::MODE_READ) begin
          state_d = in_bmp ? blr_pkg::ST_FETCH : blr_pkg::ST_DONE;
        end else if (in_bmp) begin
          state_d = blr_pkg::ST_MODIFY;
        end else if (step_stat.at_end) begin
          state_d = blr_pkg::ST_DONE;
        end
      end
      blr_pkg::ST_MODIFY: begin
        state_d = step_stat.at_end ? blr_pkg::ST_DONE : blr_pkg::ST_PLOT;
      end
      blr_pkg::ST_FETCH: state_d = blr_pkg::ST_DONE;
      blr_pkg::ST_DONE: begin
        if (!m_valid_q || m_axis_tready_i) state_d = blr_pkg::ST_IDLE;
      end
      default: state_d = blr_pkg::ST_CLEAR;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready_o  = (state_q == blr_pkg::ST_IDLE);
    step_ctl.load    = accept;
    step_ctl.advance = ((state_q == blr_pkg::ST_PLOT) && (mode_q == blr_pkg::MODE_DRAW)
                        && !in_bmp && !step_stat.at_end)
                    || ((state_q == blr_pkg::ST_MODIFY) && !step_stat.at_end);
    mem_re   = (state_q == blr_pkg::ST_PLOT) && in_bmp;
    mem_we   = (state_q == blr_pkg::ST_CLEAR) || (state_q == blr_pkg::ST_MODIFY);
    out_load = (state_q == blr_pkg::ST_DONE) && (!m_valid_q || m_axis_tready_i);
  end

  // Write data: zero while clearing, else the fetched byte with one bit changed
  always_comb begin
    mask  = 8'h01 << bit_q;
    waddr = (state_q == blr_pkg::ST_CLEAR) ? clr_q : addr_q;
    if (state_q == blr_pkg::ST_CLEAR) begin
      wdata = 8'h00;
    end else if (set_q) begin
      wdata = rdata_q | mask;
    end else begin
      wdata = rdata_q & ~mask;
    end
  end

  // Bitmap store
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= wdata;
    if (mem_re) rdata_q <= mem[byte_idx];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= blr_pkg::ST_CLEAR;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == blr_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Hold request fields, pixel location and result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= s_axis_tuser_i;
      set_q  <= s_axis_tdata_i[40];
    end
    if (mem_re) begin
      addr_q <= byte_idx;
      bit_q  <= ~step_stat.x[2:0];
    end
    if (state_q == blr_pkg::ST_PLOT) pix_q <= 1'b0;
    if (state_q == blr_pkg::ST_FETCH) pix_q <= rdata_q[bit_q];
    if (out_load) begin
      m_axis_tdata_o <= {7'b0000000, pix_q};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;

endmodule

/* hdl/blr_stepper.sv */
// Bresenham line stepper: holds the error term and walks one pixel per advance.
module blr_stepper (
  input  logic               clk_i,
  input  blr_pkg::step_ctl_t ctl_i,
  input  blr_pkg::coord_t    start_x_i,
  input  blr_pkg::coord_t    start_y_i,
  input  blr_pkg::coord_t    end_x_i,
  input  blr_pkg::coord_t    end_y_i,
  output blr_pkg::step_stat_t stat_o
);

  blr_pkg::coord_t x_q, x_d, y_q, y_d, ex_q, ey_q;
  logic            stx_q, sty_q;
  logic [9:0]      ax_q;
  logic signed [10:0] ny_q;
  logic signed [12:0] acc_q, acc_d;

  logic signed [10:0] ddx, ddy, ny_new;
  logic [9:0]         ax_new;
  logic signed [13:0] twice, ny14, ax14;
  logic signed [12:0] ny13, ax13;
  logic               go_x, go_y;

  // Set up deltas and the initial error term from the request
  always_comb begin
    ddx    = {end_x_i[9], end_x_i} - {start_x_i[9], start_x_i};
    ddy    = {end_y_i[9], end_y_i} - {start_y_i[9], start_y_i};
    ax_new = ddx[10] ? 10'(-ddx) : ddx[9:0];
    ny_new = ddy[10] ? ddy : -ddy;
  end

  // Decide the step on each axis and the new error term
  always_comb begin
    twice = {acc_q, 1'b0};
    ny14  = {{3{ny_q[10]}}, ny_q};
    ax14  = $signed({4'b0000, ax_q});
    ny13  = {{2{ny_q[10]}}, ny_q};
    ax13  = $signed({3'b000, ax_q});
    go_x  = (twice >= ny14);
    go_y  = (twice <= ax14);
    acc_d = acc_q + (go_x ? ny13 : 13'sd0) + (go_y ? ax13 : 13'sd0);
    x_d   = go_x ? (x_q + (stx_q ? 10'sd1 : -10'sd1)) : x_q;
    y_d   = go_y ? (y_q + (sty_q ? 10'sd1 : -10'sd1)) : y_q;
  end

  // Load a new line or advance one pixel
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      x_q   <= start_x_i;
      y_q   <= start_y_i;
      ex_q  <= end_x_i;
      ey_q  <= end_y_i;
      stx_q <= (start_x_i < end_x_i);
      sty_q <= (start_y_i < end_y_i);
      ax_q  <= ax_new;
      ny_q  <= ny_new;
      acc_q <= $signed({3'b000, ax_new}) + {{2{ny_new[10]}}, ny_new};
    end else if (ctl_i.advance) begin
      x_q   <= x_d;
      y_q   <= y_d;
      acc_q <= acc_d;
    end
  end

  assign stat_o.x      = x_q;
  assign stat_o.y      = y_q;
  assign stat_o.at_end = (x_q == ex_q) && (y_q == ey_q);

endmodule

/* hdl/blr_checker.sv */
// Port-level checks of the bitmap line rasterizer, bound to the top level.
module blr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [blr_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // Only the pixel bit may be set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[7:1] == 7'b0000000))
    else $error("result padding not zero");

  // One request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while busy");

  // No result appears the cycle after a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !$rose(m_axis_tvalid_o))
    else $error("result raised too early");

endmodule

bind bitmap_line_rasterizer blr_checker u_blr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

/* verif/bitmap_line_rasterizer_tb.sv */
// Self-checking testbench for the bitmap line rasterizer: line draws and pixel reads.
module bitmap_line_rasterizer_tb;

  // Hang guard: every request a longest on-bitmap draw, plus the clearing pass, several times over
  localparam int LIMIT_CYCLES  = blr_pkg::STORE_BYTES + 620 * 2100 * 4;
  localparam int RANDOM_ITEMS  = 580;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_PRINTED   = 40;

  typedef struct {
    logic            mode;
    blr_pkg::coord_t sx;
    blr_pkg::coord_t sy;
    blr_pkg::coord_t ex;
    blr_pkg::coord_t ey;
    logic            set_on;
    bit              drain_first;
    int              phase;
  } raster_req_t;

  logic                           clk;
  logic                           rst_n            = 1'b0;
  logic                           s_axis_tvalid    = 1'b0;
  logic                           s_axis_tready;
  logic [blr_pkg::IN_DATA_W-1:0]  s_axis_tdata     = '0;
  logic                           s_axis_tuser     = blr_pkg::MODE_DRAW;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready    = 1'b0;
  logic [blr_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  raster_req_t pend_q[$];
  logic        pixel_expect_q[$];
  logic [7:0]  frame_bytes [blr_pkg::STORE_BYTES];

  // Per-phase idle percentages: sender busy first, then receiver busy, then full rate
  int send_idle_pct [3] = '{18, 52, 0};
  int recv_idle_pct [3] = '{52, 18, 0};
  int pace_phase        = 0;

  bit req_taken  = 1'b0;
  int err_count  = 0;
  int cycle_count = 0;
  int n_draw     = 0;
  int n_long     = 0;
  int n_clear    = 0;
  int n_read     = 0;
  int n_read_set = 0;
  int n_results  = 0;

  bitmap_line_rasterizer i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  // Clock: period 4
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Frame predictor
  // ---------------------------------------------------------------------------

  function automatic bit on_frame(int x, int y);
    return x >= 0 && y >= 0 && x < blr_pkg::BITMAP_WIDTH && y < blr_pkg::BITMAP_HEIGHT;
  endfunction

  function automatic logic frame_pixel(int x, int y);
    if (!on_frame(x, y)) return 1'b0;
    return frame_bytes[y * blr_pkg::LINE_BYTES + x / 8][7 - x % 8];
  endfunction

  // Set or clear one pixel; skip it when it lies off the frame
  function automatic void plot_pixel(int x, int y, logic on);
    if (on_frame(x, y)) begin
      frame_bytes[y * blr_pkg::LINE_BYTES + x / 8][7 - x % 8] = on;
    end
  endfunction

  // Bresenham walk, both endpoints included, stepping on through off-frame pixels
  function automatic void trace_line(int xa, int ya, int xb, int yb, logic on);
    int ax;
    int ny;
    int stx;
    int sty;
    int acc;
    int twice;
    ax  = (xb > xa) ? xb - xa : xa - xb;
    ny  = (yb > ya) ? ya - yb : yb - ya;
    stx = (xa < xb) ? 1 : -1;
    sty = (ya < yb) ? 1 : -1;
    acc = ax + ny;
    while (1'b1) begin
      plot_pixel(xa, ya, on);
      if (xa == xb && ya == yb) break;
      twice = 2 * acc;
      if (twice >= ny) begin
        acc += ny;
        xa  += stx;
      end
      if (twice <= ax) begin
        acc += ax;
        ya  += sty;
      end
    end
  endfunction

  // Apply one accepted request to the frame and return the expected pixel_value
  function automatic logic predict_pixel(logic mode, blr_pkg::coord_t sx, blr_pkg::coord_t sy,
                                         blr_pkg::coord_t ex, blr_pkg::coord_t ey, logic on);
    if (mode == blr_pkg::MODE_READ) return frame_pixel(int'(sx), int'(sy));
    trace_line(int'(sx), int'(sy), int'(ex), int'(ey), on);
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int clamp10(int v);
    if (v < -512) return -512;
    if (v > 511) return 511;
    return v;
  endfunction

  function automatic int any_coord();
    return -512 + int'($urandom_range(1023));
  endfunction

  task automatic queue_request(logic mode, int sx, int sy, int ex, int ey, logic on,
                               bit drain_first, int phase);
    raster_req_t r;
    r.mode        = mode;
    r.sx          = blr_pkg::coord_t'(sx);
    r.sy          = blr_pkg::coord_t'(sy);
    r.ex          = blr_pkg::coord_t'(ex);
    r.ey          = blr_pkg::coord_t'(ey);
    r.set_on      = on;
    r.drain_first = drain_first;
    r.phase       = phase;
    pend_q.push_back(r);
    if (mode == blr_pkg::MODE_DRAW) begin
      n_draw++;
      if (!on) n_clear++;
    end else begin
      n_read++;
    end
  endtask

  task automatic flag_mismatch(string what);
    err_count++;
    if (err_count <= MAX_PRINTED) $display("ERROR @%0t: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: present at the falling edge, hold until accepted
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_requests
    raster_req_t nxt;
    if (!rst_n) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || req_taken) begin
      if (pend_q.size() != 0 &&
          !(pend_q[0].drain_first && pixel_expect_q.size() != 0) &&
          $urandom_range(99) >= send_idle_pct[pend_q[0].phase]) begin
        nxt = pend_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= nxt.mode;
        s_axis_tdata  <= {7'b0, nxt.set_on, nxt.ey, nxt.ex, nxt.sy, nxt.sx};
        pace_phase    <= nxt.phase;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: stall at random according to the current phase
  always @(negedge clk) begin
    m_axis_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct[pace_phase]);
  end

  // ---------------------------------------------------------------------------
  // Monitor: check results, then predict accepted requests
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_ports
    logic want;
    req_taken = rst_n && s_axis_tvalid && s_axis_tready;
    if (rst_n) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (pixel_expect_q.size() == 0) begin
          flag_mismatch("result with no request outstanding");
        end else begin
          want = pixel_expect_q.pop_front();
          if (m_axis_tdata[0] !== want) begin
            flag_mismatch($sformatf("result %0d: pixel_value %b, expected %b",
                                    n_results, m_axis_tdata[0], want));
          end
        end
      end
      if (req_taken) begin
        want = predict_pixel(s_axis_tuser, s_axis_tdata[9:0], s_axis_tdata[19:10],
                             s_axis_tdata[29:20], s_axis_tdata[39:30], s_axis_tdata[40]);
        if (s_axis_tuser == blr_pkg::MODE_READ && want) n_read_set++;
        pixel_expect_q.push_back(want);
      end
    end
  end

  // Hang guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pixel_expect_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int n;
    int pick;
    int r2;
    int k;
    int phase;
    int sx;
    int sy;
    int ex;
    int ey;
    int lx0;
    int ly0;
    int lx1;
    int ly1;

    lx0 = 0;
    ly0 = 0;
    lx1 = 0;
    ly1 = 0;
    for (int i = 0; i < blr_pkg::STORE_BYTES; i++) frame_bytes[i] = 8'h00;

    // Directed: fresh frame, single points, frame corners, off-frame reads
    queue_request(blr_pkg::MODE_READ, 0, 0, 0, 0, 1'b0, 0, 0);
    queue_request(blr_pkg::MODE_DRAW, 0, 0, 0, 0, 1'b1, 0, 0);
    queue_request(blr_pkg::MODE_READ, 0, 0, 0, 0, 1'b0, 0, 0);
    queue_request(blr_pkg::MODE_DRAW, 319, 199, 319, 199, 1'b1, 0, 0);
    queue_request(blr_pkg::MODE_READ, 319, 199, 0, 0, 1'b0, 0, 0);
    queue_request(blr_pkg::MODE_READ, -1, 0, 0, 0, 1'b0, 0, 0);
    queue_request(blr_pkg::MODE_READ, 0, -1, 0, 0, 1'b0, 0, 0);
    queue_request(blr_pkg::MODE_READ, 320, 5, 0, 0, 1'b0, 0, 0);
    queue_request(blr_pkg::MODE_READ, 5, 200, 0, 0, 1'b0, 0, 0);
    queue_request(blr_pkg::MODE_READ, -512, -512, 511, 511, 1'b1, 0, 0);
    queue_request(blr_pkg::MODE_READ, 511, 511, -512, -512, 1'b1, 0, 0);
    // Longest diagonal, entering and leaving the frame; drain before reading it back
    queue_request(blr_pkg::MODE_DRAW, -512, -512, 511, 511, 1'b1, 0, 0);
    queue_request(blr_pkg::MODE_READ, 150, 150, 0, 0, 1'b0, 1, 0);
    // Full-width row and full-height column touching both bit ends of a byte
    queue_request(blr_pkg::MODE_DRAW, 0, 20, 319, 20, 1'b1, 0, 0);
    queue_request(blr_pkg::MODE_READ, 8, 20, 0, 0, 1'b0, 0, 0);
    queue_request(blr_pkg::MODE_DRAW, 7, 0, 7, 199, 1'b1, 0, 0);
    queue_request(blr_pkg::MODE_READ, 7, 120, 0, 0, 1'b0, 0, 0);
    // Clear the row again, drawn in the opposite direction
    queue_request(blr_pkg::MODE_DRAW, 319, 20, 0, 20, 1'b0, 0, 0);
    queue_request(blr_pkg::MODE_READ, 8, 20, 0, 0, 1'b0, 0, 0);
    queue_request(blr_pkg::MODE_READ, 7, 20, 0, 0, 1'b0, 0, 0);
    // Lines with off-frame endpoints, a steep one, and one that never meets the frame
    queue_request(blr_pkg::MODE_DRAW, -300, 400, 500, -100, 1'b1, 0, 0);
    queue_request(blr_pkg::MODE_DRAW, 100, 50, 103, 190, 1'b1, 0, 0);
    queue_request(blr_pkg::MODE_READ, 103, 190, 0, 0, 1'b0, 0, 0);
    queue_request(blr_pkg::MODE_DRAW, 511, -512, -512, 511, 1'b1, 0, 0);
    queue_request(blr_pkg::MODE_READ, 0, 0, 0, 0, 1'b0, 0, 0);

    // Random: lines, mostly short and near the frame, and reads, some aimed at the last line
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      phase = n * 3 / RANDOM_ITEMS;
      pick  = $urandom_range(99);
      r2    = $urandom_range(99);
      if (pick < 45) begin
        sx = -20 + int'($urandom_range(359));
        sy = -20 + int'($urandom_range(239));
        if (r2 < 4) begin
          sx = any_coord();
          sy = any_coord();
          ex = any_coord();
          ey = any_coord();
          n_long++;
        end else if (r2 < 9) begin
          ex = any_coord();
          ey = any_coord();
          n_long++;
        end else if (r2 < 13) begin
          ex = clamp10(sx + int'($urandom_range(160)) - 80);
          ey = sy;
        end else if (r2 < 17) begin
          ex = sx;
          ey = clamp10(sy + int'($urandom_range(160)) - 80);
        end else if (r2 < 21) begin
          k  = int'($urandom_range(60)) - 30;
          ex = clamp10(sx + k);
          ey = clamp10(sy + (($urandom_range(1) == 1) ? k : -k));
        end else if (r2 < 25) begin
          ex = sx;
          ey = sy;
        end else begin
          ex = clamp10(sx + int'($urandom_range(48)) - 24);
          ey = clamp10(sy + int'($urandom_range(48)) - 24);
        end
        lx0 = sx;
        ly0 = sy;
        lx1 = ex;
        ly1 = ey;
        queue_request(blr_pkg::MODE_DRAW, sx, sy, ex, ey, $urandom_range(99) < 75,
                      (n % 97) == 96, phase);
      end else begin
        if (r2 < 35) begin
          k  = $urandom_range(4);
          sx = lx0 + (lx1 - lx0) * k / 4;
          sy = ly0 + (ly1 - ly0) * k / 4;
        end else if (r2 < 75) begin
          sx = $urandom_range(blr_pkg::BITMAP_WIDTH - 1);
          sy = $urandom_range(blr_pkg::BITMAP_HEIGHT - 1);
        end else if (r2 < 88) begin
          sx = (($urandom_range(1) == 1) ? blr_pkg::BITMAP_WIDTH - 2 : -2)
             + int'($urandom_range(3));
          sy = (($urandom_range(1) == 1) ? blr_pkg::BITMAP_HEIGHT - 2 : -2)
             + int'($urandom_range(3));
        end else begin
          sx = any_coord();
          sy = any_coord();
        end
        // Unused fields on a read still carry random bits
        queue_request(blr_pkg::MODE_READ, sx, sy, any_coord(), any_coord(),
                      1'($urandom_range(1)), (n % 97) == 96, phase);
      end
    end

    // Hold reset, then release it at a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every request to go in and every result to come back
    while (pend_q.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (pixel_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d line draws (%0d spanning the full coordinate range, %0d clearing)",
             n_draw, n_long, n_clear);
    $display("and %0d pixel reads (%0d found set), %0d results checked, %0d errors",
             n_read, n_read_set, n_results, err_count);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
